FILE: hdl/ecw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecw_pkg
// Shared types and constants of the electromagnet commutation window engine.
// ----------------------------------------------------------------------------
package ecw_pkg;

	localparam int ANGLE_W    = 16;
	localparam int MAX_COILS  = 64;
	localparam int COIL_IDX_W = $clog2(MAX_COILS);
	localparam int COUNT_W    = $clog2(MAX_COILS + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(1) << (ANGLE_W - 1);

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COIL_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_MODE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd4;

	localparam logic [6:0]         RST_COIL_COUNT   = 7'd4;
	localparam logic               RST_PAIR_MODE    = 1'b1;
	localparam logic [ANGLE_W-1:0] RST_HALF_WINDOW  = 16'd1820;
	localparam logic [ANGLE_W-1:0] RST_ANGLE_STEP   = 16'd546;
	localparam logic [ANGLE_W-1:0] RST_ANGLE_OFFSET = 16'd0;

	typedef struct packed {
		logic [6:0]         coil_count;
		logic               pair_mode;
		logic [ANGLE_W-1:0] half_window;
		logic [ANGLE_W-1:0] angle_step;
		logic [ANGLE_W-1:0] angle_offset;
	} ecw_cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]   rotor_angle;
		logic [ANGLE_W-1:0]   piece_pos;
		logic [MAX_COILS-1:0] active_mask;
		logic [COUNT_W-1:0]   active_count;
	} ecw_result_t;

	typedef struct packed {
		logic                  wr_en;
		logic [COIL_IDX_W-1:0] wr_addr;
		logic [ANGLE_W-1:0]    wr_data;
	} ecw_wr_t;

endpackage
`default_nettype wire

FILE: hdl/ecw_coil_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecw_coil_table
// Firing angle table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ecw_coil_table
	import ecw_pkg::*;
(
	input  wire logic                  clk,
	input  wire ecw_wr_t               wr,
	input  wire logic                  rd_en,
	input  wire logic [COIL_IDX_W-1:0] rd_addr,
	output logic      [ANGLE_W-1:0]    rd_data
);

	logic [ANGLE_W-1:0] mem [MAX_COILS];

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.wr_addr] <= wr.wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ecw_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecw_scan
// Tick sequencer: advances the rotor, walks the coil table one entry per
// cycle and builds the active mask and its count.
// ----------------------------------------------------------------------------
module ecw_scan
	import ecw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ecw_cfg_t              cfg,
	input  wire logic                  start,
	input  wire logic                  res_take,
	output logic                       idle,
	output logic                       res_valid,
	output ecw_result_t                res,
	output logic                       rd_en,
	output logic      [COIL_IDX_W-1:0] rd_addr,
	input  wire logic [ANGLE_W-1:0]    rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [ANGLE_W-1:0]    rotor_q;
	logic [ANGLE_W-1:0]    piece_q;
	logic [COIL_IDX_W-1:0] rd_idx_q;
	logic [COIL_IDX_W-1:0] last_q;
	logic                  valid_s1;
	logic                  last_s1;
	logic [COIL_IDX_W-1:0] idx_s1;
	logic [MAX_COILS-1:0]  mask_q;
	logic [COUNT_W-1:0]    count_q;

	logic [ANGLE_W-1:0]    rotor_next;
	logic [COIL_IDX_W-1:0] last_next;
	logic [ANGLE_W-1:0]    diff;
	logic [ANGLE_W-1:0]    ang_dist;
	logic                  hit;
	logic [COIL_IDX_W-1:0] nx;
	logic                  new_cur;
	logic                  new_nx;

	assign rotor_next = rotor_q + cfg.angle_step;

	always_comb begin
		if (cfg.coil_count == 7'd0) begin
			last_next = '0;
		end else if (cfg.coil_count >= 7'(MAX_COILS)) begin
			last_next = COIL_IDX_W'(MAX_COILS - 1);
		end else begin
			last_next = COIL_IDX_W'(cfg.coil_count - 7'd1);
		end
	end

	assign diff     = piece_q - rd_data;
	assign ang_dist = (diff > HALF_TURN) ? (ANGLE_W'(0) - diff) : diff;
	assign hit      = valid_s1 && (ang_dist <= cfg.half_window);
	assign nx       = last_s1 ? '0 : idx_s1 + COIL_IDX_W'(1);
	assign new_cur  = hit && !mask_q[idx_s1];
	assign new_nx   = hit && cfg.pair_mode && (nx != idx_s1) && !mask_q[nx];

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign rd_en     = (state_q == ST_SCAN);
	assign rd_addr   = rd_idx_q;

	assign res.rotor_angle  = rotor_q;
	assign res.piece_pos    = piece_q;
	assign res.active_mask  = mask_q;
	assign res.active_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rotor_q  <= '0;
			piece_q  <= '0;
			rd_idx_q <= '0;
			last_q   <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
			mask_q   <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (hit) begin
				mask_q[idx_s1] <= 1'b1;
				if (cfg.pair_mode) begin
					mask_q[nx] <= 1'b1;
				end
				count_q <= count_q + COUNT_W'(new_cur) + COUNT_W'(new_nx);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rotor_q  <= rotor_next;
						piece_q  <= rotor_next + cfg.angle_offset;
						rd_idx_q <= '0;
						last_q   <= last_next;
						mask_q   <= '0;
						count_q  <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					valid_s1 <= 1'b1;
					idx_s1   <= rd_idx_q;
					last_s1  <= (rd_idx_q == last_q);
					if (rd_idx_q == last_q) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + COIL_IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (valid_s1 && last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= last_q))
		else $error("Table read beyond the last coil in use.");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (count_q == COUNT_W'($countones(mask_q))))
		else $error("Active count differs from the mask population.");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !valid_s1)
		else $error("Compare stage busy while the sequencer is idle.");

	a_done_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> $stable(mask_q))
		else $error("Mask changed after the scan finished.");
`endif

endmodule
`default_nettype wire

FILE: hdl/electromagnet_commutation_window.sv
`default_nettype none
// A tick word walks the n coils in use (1 to 64) one table entry per cycle; its
// result enters the output register when the input becomes ready again, so a
// new word is accepted only once the last tick is through.
// A result held back while the output register is full stalls the input.
// A write word gives no result. Reset zeroes the rotor angle
// and loads the register defaults; the coil table is undefined until written.
// ----------------------------------------------------------------------------
// electromagnet_commutation_window
// Top level: input and configuration ports, coil table, tick sequencer and
// the output register.
// ----------------------------------------------------------------------------
module electromagnet_commutation_window
	import ecw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [COIL_IDX_W-1:0] coil_index,
	input  wire logic [ANGLE_W-1:0]    coil_angle,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [ANGLE_W-1:0]    rotor_angle,
	output logic      [ANGLE_W-1:0]    piece_pos,
	output logic      [MAX_COILS-1:0]  active_mask,
	output logic      [COUNT_W-1:0]    active_count
);

	ecw_cfg_t              cfg_q;
	ecw_wr_t               wr;
	ecw_result_t           res;
	ecw_result_t           out_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  start;
	logic                  idle;
	logic                  res_valid;
	logic                  res_take;
	logic                  rd_en;
	logic [COIL_IDX_W-1:0] rd_addr;
	logic [ANGLE_W-1:0]    rd_data;

	assign in_ready = idle;
	assign accept   = in_valid && in_ready;
	assign start    = accept && (op == OP_TICK);
	assign res_take = res_valid && (!out_valid_q || out_ready);

	assign wr.wr_en   = accept && (op == OP_WRITE);
	assign wr.wr_addr = coil_index;
	assign wr.wr_data = coil_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coil_count   <= RST_COIL_COUNT;
			cfg_q.pair_mode    <= RST_PAIR_MODE;
			cfg_q.half_window  <= RST_HALF_WINDOW;
			cfg_q.angle_step   <= RST_ANGLE_STEP;
			cfg_q.angle_offset <= RST_ANGLE_OFFSET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COIL_COUNT:   cfg_q.coil_count   <= cfg_data[6:0];
				REG_PAIR_MODE:    cfg_q.pair_mode    <= cfg_data[0];
				REG_HALF_WINDOW:  cfg_q.half_window  <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_OFFSET: cfg_q.angle_offset <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	ecw_coil_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ecw_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.res_take  (res_take),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign rotor_angle  = out_q.rotor_angle;
	assign piece_pos    = out_q.piece_pos;
	assign active_mask  = out_q.active_mask;
	assign active_count = out_q.active_count;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the electromagnet commutation window engine.
// Directed tests cover the reset defaults, the edges of the match window,
// the coil count limits, extreme steps and offsets, ignored register
// indexes and a long output stall. Random phases then reconfigure the block,
// lay out coil tables and run tick and table words with random idling on
// both sides. Every tick is predicted in the bench and each result word is
// compared field by field.
// ----------------------------------------------------------------------------
module tb
	import ecw_pkg::*;
();

	localparam int CLK_HALF      = 6;
	localparam int SETTLE_CYCLES = MAX_COILS + 8;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_WORDS  = 1950;
	localparam int FIRST_BAD_REG = REG_ANGLE_OFFSET + 1;
	localparam int LAST_BAD_REG  = (1 << CFG_IDX_W) - 1;
	localparam int MAX_REPORTS   = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  op;
	logic [COIL_IDX_W-1:0] coil_index;
	logic [ANGLE_W-1:0]    coil_angle;
	logic                  out_valid;
	logic                  out_ready;
	logic [ANGLE_W-1:0]    rotor_angle;
	logic [ANGLE_W-1:0]    piece_pos;
	logic [MAX_COILS-1:0]  active_mask;
	logic [COUNT_W-1:0]    active_count;

	logic [6:0]         m_coil_count;
	logic               m_pair_mode;
	logic [ANGLE_W-1:0] m_half_window;
	logic [ANGLE_W-1:0] m_angle_step;
	logic [ANGLE_W-1:0] m_angle_offset;
	logic [ANGLE_W-1:0] m_rotor;
	logic [ANGLE_W-1:0] m_coil_table [MAX_COILS];

	ecw_result_t expected_windows [$];
	ecw_result_t want;

	int  err_count    = 0;
	int  tick_words   = 0;
	int  table_words  = 0;
	int  reg_writes   = 0;
	int  settings     = 0;
	int  results_seen = 0;
	int  cycles       = 0;
	int  rx_hold      = 0;
	bit  tx_idle_en   = 1'b1;
	bit  rx_idle_en   = 1'b1;

	electromagnet_commutation_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.coil_index(coil_index),
		.coil_angle(coil_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rotor_angle(rotor_angle),
		.piece_pos(piece_pos),
		.active_mask(active_mask),
		.active_count(active_count)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [ANGLE_W:0] circular_distance(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [ANGLE_W-1:0] d;
		d = a - b;
		if (d > HALF_TURN)
			return (17'd1 << ANGLE_W) - {1'b0, d};
		return {1'b0, d};
	endfunction

	function automatic ecw_result_t evaluate_tick();
		ecw_result_t r;
		int n;
		int nx;
		logic [ANGLE_W-1:0] piece;
		n = m_coil_count;
		if (n < 1)
			n = 1;
		if (n > MAX_COILS)
			n = MAX_COILS;
		m_rotor = m_rotor + m_angle_step;
		piece = m_rotor + m_angle_offset;
		r.rotor_angle = m_rotor;
		r.piece_pos = piece;
		r.active_mask = '0;
		for (int i = 0; i < n; i++) begin
			if (circular_distance(piece, m_coil_table[i]) <= {1'b0, m_half_window}) begin
				r.active_mask[i] = 1'b1;
				if (m_pair_mode) begin
					nx = (i + 1 == n) ? 0 : i + 1;
					r.active_mask[nx] = 1'b1;
				end
			end
		end
		r.active_count = COUNT_W'($countones(r.active_mask));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_windows.size() == 0) begin
				report_mismatch("unexpected result word", active_mask, '0);
			end else begin
				want = expected_windows.pop_front();
				if (rotor_angle !== want.rotor_angle)
					report_mismatch("rotor_angle", rotor_angle, want.rotor_angle);
				if (piece_pos !== want.piece_pos)
					report_mismatch("piece_pos", piece_pos, want.piece_pos);
				if (active_mask !== want.active_mask)
					report_mismatch("active_mask", active_mask, want.active_mask);
				if (active_count !== want.active_count)
					report_mismatch("active_count", active_count, want.active_count);
			end
		end
	end

	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = rx_idle_en ? idle_len() : 0;
			end
		end
	end

	initial begin : watchdog
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles without finishing.", cycles);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_word(input logic word_op, input logic [COIL_IDX_W-1:0] idx,
			input logic [ANGLE_W-1:0] ang);
		int gap;
		gap = tx_idle_en ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= word_op;
		coil_index <= idx;
		coil_angle <= ang;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (word_op == OP_WRITE) begin
			m_coil_table[idx] = ang;
			table_words++;
		end else begin
			expected_windows.push_back(evaluate_tick());
			tick_words++;
		end
	endtask

	task automatic tick();
		send_word(OP_TICK, COIL_IDX_W'($urandom), ANGLE_W'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_COIL_COUNT:   m_coil_count   = data[6:0];
			REG_PAIR_MODE:    m_pair_mode    = data[0];
			REG_HALF_WINDOW:  m_half_window  = data;
			REG_ANGLE_STEP:   m_angle_step   = data;
			REG_ANGLE_OFFSET: m_angle_offset = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input int cc, input bit pm, input int hw, input int st,
			input int off, input bit noisy);
		drain();
		write_reg(REG_COIL_COUNT, {(noisy ? 9'($urandom) : 9'd0), 7'(cc)});
		write_reg(REG_PAIR_MODE, {(noisy ? 15'($urandom) : 15'd0), pm});
		write_reg(REG_HALF_WINDOW, 16'(hw));
		write_reg(REG_ANGLE_STEP, 16'(st));
		write_reg(REG_ANGLE_OFFSET, 16'(off));
		cfg_write <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	task automatic test_reset_defaults();
		for (int i = 0; i < MAX_COILS; i++)
			send_word(OP_WRITE, COIL_IDX_W'(i), (i < 4) ? 16'(i * 16384) : 16'($urandom));
		repeat (4) tick();
	endtask

	task automatic test_window_edges();
		logic [ANGLE_W-1:0] p;
		configure(4, 1'b0, 100, 0, 16'h1234, 1'b0);
		p = m_rotor + m_angle_offset;
		send_word(OP_WRITE, COIL_IDX_W'(0), p + 16'd100);
		send_word(OP_WRITE, COIL_IDX_W'(1), p - 16'd101);
		send_word(OP_WRITE, COIL_IDX_W'(2), p - 16'd100);
		send_word(OP_WRITE, COIL_IDX_W'(3), p + HALF_TURN);
		tick();
		configure(4, 1'b0, 32767, 0, 16'h1234, 1'b0);
		tick();
		configure(4, 1'b0, 32768, 0, 16'h1234, 1'b0);
		tick();
		configure(4, 1'b1, 65535, 0, 16'h1234, 1'b0);
		tick();
		configure(4, 1'b1, 0, 0, 16'h1234, 1'b0);
		send_word(OP_WRITE, COIL_IDX_W'(1), p);
		tick();
	endtask

	task automatic test_coil_count_limits();
		logic [ANGLE_W-1:0] p;
		configure(0, 1'b1, 0, 0, 0, 1'b0);
		p = m_rotor + m_angle_offset;
		send_word(OP_WRITE, COIL_IDX_W'(0), p);
		tick();
		configure(127, 1'b1, 32768, 300, 0, 1'b1);
		tick();
		configure(64, 1'b1, 10, 0, 0, 1'b0);
		p = m_rotor + m_angle_offset;
		send_word(OP_WRITE, COIL_IDX_W'(63), p);
		tick();
		configure(65, 1'b0, 10, 0, 0, 1'b0);
		tick();
	endtask

	task automatic test_step_extremes();
		configure(8, 1'b1, 4096, -32768, 16'hFFFF, 1'b0);
		repeat (3) tick();
		configure(8, 1'b0, 4096, 32767, 16'h8000, 1'b0);
		repeat (3) tick();
		configure(8, 1'b1, 4096, -1, 1, 1'b1);
		repeat (2) tick();
	endtask

	task automatic test_ignored_registers();
		drain();
		for (int k = FIRST_BAD_REG; k <= LAST_BAD_REG; k++)
			write_reg(CFG_IDX_W'(k), 16'($urandom));
		cfg_write <= 1'b0;
		@(posedge clk);
		repeat (3) tick();
	endtask

	task automatic test_output_stall();
		configure(4, 1'b1, 8000, 3000, 0, 1'b0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rx_hold = 400;
		repeat (16) tick();
		drain();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		int sent;
		int r;
		int cc;
		int n;
		int spacing;
		int hw;
		int st;
		int burst;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(99);
			if (r < 60)
				cc = $urandom_range(8, 1);
			else if (r < 85)
				cc = $urandom_range(32, 9);
			else if (r < 95)
				cc = $urandom_range(64, 33);
			else
				cc = $urandom_range(1) ? 0 : $urandom_range(127, 65);
			n = (cc < 1) ? 1 : ((cc > MAX_COILS) ? MAX_COILS : cc);
			spacing = 65536 / n;
			r = $urandom_range(99);
			if (r < 70)
				hw = $urandom_range((spacing > 65535) ? 65535 : spacing, 0);
			else if (r < 90)
				hw = $urandom_range(65535, 0);
			else
				hw = ($urandom_range(1) ? 0 : 32767) + $urandom_range(1);
			r = $urandom_range(99);
			if (r < 60)
				st = $urandom_range(2000, 0) - 1000;
			else if (r < 95)
				st = $urandom_range(65535, 0);
			else
				st = 0;
			configure(cc, 1'($urandom), hw, st, $urandom_range(65535, 0), 1'($urandom));
			r = $urandom_range(3);
			tx_idle_en = r[0];
			rx_idle_en = r[1];
			if ($urandom_range(99) < 5)
				rx_hold = $urandom_range(300, 100);
			if ($urandom_range(1)) begin
				for (int i = 0; i < n; i++) begin
					send_word(OP_WRITE, COIL_IDX_W'(i),
						16'(i * spacing + $urandom_range(spacing / 4) - spacing / 8));
					sent++;
				end
			end
			burst = $urandom_range(80, 30);
			repeat (burst) begin
				if ($urandom_range(99) < 85)
					tick();
				else
					send_word(OP_WRITE, COIL_IDX_W'($urandom), ANGLE_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		cfg_write  = 1'b0;
		cfg_index  = REG_COIL_COUNT;
		cfg_data   = '0;
		in_valid   = 1'b0;
		op         = OP_TICK;
		coil_index = '0;
		coil_angle = '0;
		arst_n     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		m_coil_count   = RST_COIL_COUNT;
		m_pair_mode    = RST_PAIR_MODE;
		m_half_window  = RST_HALF_WINDOW;
		m_angle_step   = RST_ANGLE_STEP;
		m_angle_offset = RST_ANGLE_OFFSET;
		m_rotor        = '0;
		@(posedge clk);

		test_reset_defaults();
		test_window_edges();
		test_coil_count_limits();
		test_step_extremes();
		test_ignored_registers();
		test_output_stall();
		test_random_phases();
		drain();

		$display("Ran %0d tick words and %0d table words under %0d register settings.",
			tick_words, table_words, settings);
		$display("Compared %0d result words; %0d field mismatches.", results_seen, err_count);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: electromagnet_commutation_window.f
hdl/ecw_pkg.sv
hdl/ecw_coil_table.sv
hdl/ecw_scan.sv
hdl/electromagnet_commutation_window.sv
test/tb.sv
